FILE: rtl/bchi_pkg.sv
// ----------------------------------------------------------------------------
// bchi_pkg: shared types and constants of the bicubic Hermite grid interpolator.
// Field widths, pipeline depths, operation codes and register indexes.
// ----------------------------------------------------------------------------
package bchi_pkg;

	localparam int DATA_W     = 32;
	localparam int COORD_W    = 16;
	localparam int CNT_W      = 7;
	localparam int IDX_W      = 6;
	localparam int FRAC_W     = 23;
	localparam int T_W        = FRAC_W + 1;
	localparam int WGT_W      = 26;
	localparam int SPC_W      = 32;
	localparam int ACC_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int DIVT_Q    = CNT_W + FRAC_W;
	localparam int DIVT_STEP = 3;
	localparam int DIVT_ST   = DIVT_Q / DIVT_STEP;
	localparam int DIVH_Q    = COORD_W + 16;
	localparam int DIVH_STEP = 4;
	localparam int DIVH_ST   = DIVH_Q / DIVH_STEP;

	localparam int AXIS_LAT  = DIVT_ST + 6;
	localparam int GRID_LAT  = 1;
	localparam int SUM_LAT   = 8;
	localparam int TOTAL_LAT = AXIS_LAT + GRID_LAT + SUM_LAT;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENERGY_MIN,
		REG_ENERGY_MAX,
		REG_BASELINE_MIN,
		REG_BASELINE_MAX,
		REG_ENERGY_POINTS,
		REG_BASELINE_POINTS
	} cfg_reg_t;

	typedef struct packed {
		logic                      operation;
		logic [IDX_W-1:0]          energy_point;
		logic [IDX_W-1:0]          baseline_point;
		logic signed [DATA_W-1:0]  point_value;
		logic signed [DATA_W-1:0]  slope_first_axis;
		logic signed [DATA_W-1:0]  slope_second_axis;
		logic signed [DATA_W-1:0]  cross_slope;
		logic [COORD_W-1:0]        query_energy;
		logic [COORD_W-1:0]        query_baseline;
	} request_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] interpolated;
		logic                     off_grid;
	} result_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] first_slope;
		logic signed [DATA_W-1:0] second_slope;
		logic signed [DATA_W-1:0] mixed_slope;
	} point_t;

	typedef struct packed {
		logic                       ok;
		logic [CNT_W-1:0]           cell_idx;
		logic [3:0][WGT_W-1:0]      w;
		logic [SPC_W-1:0]           spacing;
	} axis_t;

endpackage

FILE: rtl/bchi_div.sv
// ----------------------------------------------------------------------------
// bchi_div: pipelined restoring divider.
// Produces STEP quotient bits per stage; the partial remainder must start
// below the divisor.
// ----------------------------------------------------------------------------
module bchi_div #(
	parameter int DEN_W = 16,
	parameter int Q_W   = 30,
	parameter int STEP  = 3
) (
	input  logic             clk,
	input  logic [DEN_W-1:0] rem_init,
	input  logic [DEN_W-1:0] den,
	input  logic [Q_W-1:0]   num_low,
	output logic [Q_W-1:0]   quot
);

	localparam int NST = Q_W / STEP;

	logic [DEN_W-1:0] rem_s [NST];
	logic [DEN_W-1:0] den_s [NST];
	logic [Q_W-1:0]   num_s [NST];
	logic [Q_W-1:0]   quo_s [NST];

	for (genvar k = 0; k < NST; k++) begin : g_stage
		logic [DEN_W-1:0] rem_in, den_in, rem_nx;
		logic [Q_W-1:0]   num_in, quo_in, num_nx, quo_nx;

		if (k == 0) begin : g_first
			assign rem_in = rem_init;
			assign den_in = den;
			assign num_in = num_low;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign num_in = num_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		always_comb begin
			logic [DEN_W:0] trial;
			rem_nx = rem_in;
			num_nx = num_in;
			quo_nx = quo_in;
			for (int b = 0; b < STEP; b++) begin
				trial  = {rem_nx, num_nx[Q_W-1]};
				num_nx = {num_nx[Q_W-2:0], 1'b0};
				if (trial >= {1'b0, den_in}) begin
					rem_nx = DEN_W'(trial - {1'b0, den_in});
					quo_nx = {quo_nx[Q_W-2:0], 1'b1};
				end else begin
					rem_nx = trial[DEN_W-1:0];
					quo_nx = {quo_nx[Q_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= rem_nx;
			den_s[k] <= den_in;
			num_s[k] <= num_nx;
			quo_s[k] <= quo_nx;
		end
	end

	assign quot = quo_s[NST-1];

endmodule

FILE: rtl/bchi_axis.sv
// ----------------------------------------------------------------------------
// bchi_axis: locates a coordinate on one grid axis.
// Gives the range flag, the cell, the four Hermite basis weights and the
// cell spacing in Q16.16.
// ----------------------------------------------------------------------------
module bchi_axis #(
	parameter int MAX_POINTS = 64
) (
	input  logic                            clk,
	input  logic [bchi_pkg::COORD_W-1:0]    q,
	input  logic [bchi_pkg::COORD_W-1:0]    lo,
	input  logic [bchi_pkg::COORD_W-1:0]    hi,
	input  logic [bchi_pkg::CNT_W-1:0]      points,
	output bchi_pkg::axis_t                 geo
);

	localparam int CW  = bchi_pkg::CNT_W;
	localparam int PW  = bchi_pkg::COORD_W;
	localparam int FW  = bchi_pkg::FRAC_W;
	localparam int TW  = bchi_pkg::T_W;
	localparam int WW  = bchi_pkg::WGT_W;
	localparam int SW  = bchi_pkg::SPC_W;
	localparam int NT  = bchi_pkg::DIVT_ST;
	localparam int ND  = bchi_pkg::DIVT_ST - bchi_pkg::DIVH_ST;

	logic          ok_s1, ok_s2;
	logic [PW-1:0] span_s1, span_s2, p_s1;
	logic [CW-1:0] cells_s1, cells_s2;
	logic [PW+CW-1:0] prod_s2;

	logic [CW-1:0] n_eff;

	always_comb begin
		if (points < CW'(2)) begin
			n_eff = CW'(2);
		end else if (11'(points) > 11'(MAX_POINTS)) begin
			n_eff = CW'(MAX_POINTS);
		end else begin
			n_eff = points;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1    <= (hi > lo) && (q >= lo) && (q <= hi);
		span_s1  <= hi - lo;
		p_s1     <= q - lo;
		cells_s1 <= n_eff - CW'(1);
		ok_s2    <= ok_s1;
		span_s2  <= span_s1;
		cells_s2 <= cells_s1;
		prod_s2  <= p_s1 * cells_s1;
	end

	logic [bchi_pkg::DIVT_Q-1:0] quot_t;
	logic [SW-1:0]               quot_h;

	bchi_div #(
		.DEN_W(PW),
		.Q_W  (bchi_pkg::DIVT_Q),
		.STEP (bchi_pkg::DIVT_STEP)
	) u_div_t (
		.clk     (clk),
		.rem_init(prod_s2[PW+CW-1 -: PW]),
		.den     (span_s2),
		.num_low ({prod_s2[CW-1:0], FW'(0)}),
		.quot    (quot_t)
	);

	bchi_div #(
		.DEN_W(CW),
		.Q_W  (bchi_pkg::DIVH_Q),
		.STEP (bchi_pkg::DIVH_STEP)
	) u_div_h (
		.clk     (clk),
		.rem_init(CW'(0)),
		.den     (cells_s2),
		.num_low ({span_s2, 16'(0)}),
		.quot    (quot_h)
	);

	logic          ok_s [NT];
	logic [CW-1:0] cells_s [NT];
	logic [SW-1:0] spc_s [ND];

	always_ff @(posedge clk) begin
		ok_s[0]    <= ok_s2;
		cells_s[0] <= cells_s2;
		for (int k = 1; k < NT; k++) begin
			ok_s[k]    <= ok_s[k-1];
			cells_s[k] <= cells_s[k-1];
		end
		spc_s[0] <= quot_h;
		for (int k = 1; k < ND; k++) begin
			spc_s[k] <= spc_s[k-1];
		end
	end

	logic          ok_s13, ok_s14, ok_s15, ok_s16;
	logic [CW-1:0] cell_s13, cell_s14, cell_s15, cell_s16;
	logic [SW-1:0] spc_s13, spc_s14, spc_s15, spc_s16;
	logic [TW-1:0] t_s13, t_s14, t_s15, t2_s14, t2_s15, t3_s15;
	logic [3:0][WW-1:0] w_s16;

	logic [CW-1:0]   iq;
	logic [2*TW-1:0] sq, cu;
	logic signed [WW:0] t_x, t2_x, t3_x;
	logic signed [WW:0] one_x;

	always_comb begin
		iq    = quot_t[bchi_pkg::DIVT_Q-1 -: CW];
		sq    = t_s13 * t_s13;
		cu    = t2_s14 * t_s14;
		t_x   = $signed({3'b000, t_s15});
		t2_x  = $signed({3'b000, t2_s15});
		t3_x  = $signed({3'b000, t3_s15});
		one_x = $signed((WW+1)'(1) << FW);
	end

	always_ff @(posedge clk) begin
		ok_s13  <= ok_s[NT-1];
		spc_s13 <= spc_s[ND-1];
		if (iq >= cells_s[NT-1]) begin
			cell_s13 <= cells_s[NT-1] - CW'(1);
			t_s13    <= TW'(1) << FW;
		end else begin
			cell_s13 <= iq;
			t_s13    <= {1'b0, quot_t[FW-1:0]};
		end

		ok_s14   <= ok_s13;
		cell_s14 <= cell_s13;
		spc_s14  <= spc_s13;
		t_s14    <= t_s13;
		t2_s14   <= sq[FW +: TW];

		ok_s15   <= ok_s14;
		cell_s15 <= cell_s14;
		spc_s15  <= spc_s14;
		t_s15    <= t_s14;
		t2_s15   <= t2_s14;
		t3_s15   <= cu[FW +: TW];

		ok_s16   <= ok_s15;
		cell_s16 <= cell_s15;
		spc_s16  <= spc_s15;
		w_s16[0] <= WW'(one_x - 3 * t2_x + 2 * t3_x);
		w_s16[1] <= WW'(t_x - 2 * t2_x + t3_x);
		w_s16[2] <= WW'(3 * t2_x - 2 * t3_x);
		w_s16[3] <= WW'(t3_x - t2_x);
	end

	always_comb begin
		geo.ok       = ok_s16;
		geo.cell_idx = cell_s16;
		geo.w        = w_s16;
		geo.spacing  = spc_s16;
	end

endmodule

FILE: rtl/bchi_grid.sv
// ----------------------------------------------------------------------------
// bchi_grid: grid point storage in four banks split by index parity.
// One write and the four corners of a cell are served in each cycle.
// ----------------------------------------------------------------------------
module bchi_grid #(
	parameter int MAX_F = 64,
	parameter int MAX_S = 64
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [bchi_pkg::IDX_W-1:0]    wr_e,
	input  logic [bchi_pkg::IDX_W-1:0]    wr_l,
	input  bchi_pkg::point_t              wr_data,
	input  logic [bchi_pkg::CNT_W-1:0]    rd_i,
	input  logic [bchi_pkg::CNT_W-1:0]    rd_j,
	output bchi_pkg::point_t [3:0]        corner
);

	localparam int IW     = bchi_pkg::IDX_W;
	localparam int CW     = bchi_pkg::CNT_W;
	localparam int HALF_F = (MAX_F + 1) / 2;
	localparam int HALF_S = (MAX_S + 1) / 2;
	localparam int DEPTH  = HALF_F * HALF_S;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic          wr_ok;
	logic [1:0]    wr_bank;
	logic [AW-1:0] wr_addr;
	logic [1:0]    par_q;
	bchi_pkg::point_t rd_q [4];

	always_comb begin
		wr_ok   = wr_en && (int'(wr_e) < MAX_F) && (int'(wr_l) < MAX_S);
		wr_bank = {wr_e[0], wr_l[0]};
		wr_addr = AW'(int'(wr_e[IW-1:1]) * HALF_S + int'(wr_l[IW-1:1]));
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic PE = 1'((b >> 1) & 1);
		localparam logic PL = 1'(b & 1);

		bchi_pkg::point_t mem_q [DEPTH];
		logic [CW:0]   row_e, row_l;
		logic [AW-1:0] rd_addr;

		always_comb begin
			row_e   = {1'b0, rd_i} + {{CW{1'b0}}, PE ^ rd_i[0]};
			row_l   = {1'b0, rd_j} + {{CW{1'b0}}, PL ^ rd_j[0]};
			rd_addr = AW'(int'(row_e[CW:1]) * HALF_S + int'(row_l[CW:1]));
		end

		always_ff @(posedge clk) begin
			if (wr_ok && wr_bank == 2'(b)) begin
				mem_q[wr_addr] <= wr_data;
			end
			rd_q[b] <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		par_q <= {rd_i[0], rd_j[0]};
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			corner[k] = rd_q[2'(k) ^ par_q];
		end
	end

endmodule

FILE: rtl/bchi_sum.sv
// ----------------------------------------------------------------------------
// bchi_sum: slope scaling and the sixteen-term Hermite sum.
// Scales slopes by the spacings, forms the weight products and accumulates
// through a registered adder tree.
// ----------------------------------------------------------------------------
module bchi_sum (
	input  logic                                 clk,
	input  bchi_pkg::point_t [3:0]               corner,
	input  bchi_pkg::axis_t                      geo_e,
	input  bchi_pkg::axis_t                      geo_l,
	output logic signed [bchi_pkg::DATA_W-1:0]   value
);

	localparam int DW = bchi_pkg::DATA_W;
	localparam int WW = bchi_pkg::WGT_W;
	localparam int SW = bchi_pkg::SPC_W;
	localparam int AW = bchi_pkg::ACC_W;
	localparam int FW = bchi_pkg::FRAC_W;
	localparam int PW = DW + SW + 1;

	function automatic logic signed [DW-1:0] sat_data(input logic signed [AW-1:0] v);
		if (v[AW-1:DW-1] == '0 || v[AW-1:DW-1] == '1) begin
			return v[DW-1:0];
		end else if (v[AW-1]) begin
			return {1'b1, {(DW-1){1'b0}}};
		end else begin
			return {1'b0, {(DW-1){1'b1}}};
		end
	endfunction

	logic signed [DW-1:0]   val_s1 [4], val_s2 [4], val_s3 [4], val_s4 [4];
	logic signed [PW-1:0]   se_p_s1 [4], sl_p_s1 [4], c1_p_s1 [4], c_p_s3 [4];
	logic signed [DW-1:0]   se_s2 [4], se_s3 [4], se_s4 [4];
	logic signed [DW-1:0]   sl_s2 [4], sl_s3 [4], sl_s4 [4];
	logic signed [DW-1:0]   c1_s2 [4], c_s4 [4];
	logic signed [2*WW-1:0] wp_s1 [4][4];
	logic signed [WW-1:0]   wt_s2 [4][4], wt_s3 [4][4], wt_s4 [4][4];
	logic [SW-1:0]          hl_s1, hl_s2;
	logic signed [AW-1:0]   term_s5 [4][4];
	logic signed [AW-1:0]   grp_s6 [4];
	logic signed [AW-1:0]   acc_s7;
	logic signed [DW-1:0]   value_s8;

	always_ff @(posedge clk) begin
		hl_s1 <= geo_l.spacing;
		hl_s2 <= hl_s1;
		for (int k = 0; k < 4; k++) begin
			val_s1[k]  <= corner[k].value;
			se_p_s1[k] <= corner[k].first_slope * $signed({1'b0, geo_e.spacing});
			sl_p_s1[k] <= corner[k].second_slope * $signed({1'b0, geo_l.spacing});
			c1_p_s1[k] <= corner[k].mixed_slope * $signed({1'b0, geo_e.spacing});
			wp_s1[k][0] <= $signed(geo_e.w[2*(k>>1)])   * $signed(geo_l.w[2*(k&1)]);
			wp_s1[k][1] <= $signed(geo_e.w[2*(k>>1)+1]) * $signed(geo_l.w[2*(k&1)]);
			wp_s1[k][2] <= $signed(geo_e.w[2*(k>>1)])   * $signed(geo_l.w[2*(k&1)+1]);
			wp_s1[k][3] <= $signed(geo_e.w[2*(k>>1)+1]) * $signed(geo_l.w[2*(k&1)+1]);

			val_s2[k] <= val_s1[k];
			se_s2[k]  <= sat_data(AW'(se_p_s1[k] >>> 16));
			sl_s2[k]  <= sat_data(AW'(sl_p_s1[k] >>> 16));
			c1_s2[k]  <= sat_data(AW'(c1_p_s1[k] >>> 16));
			for (int j = 0; j < 4; j++) begin
				wt_s2[k][j] <= WW'(wp_s1[k][j] >>> FW);
			end

			val_s3[k] <= val_s2[k];
			se_s3[k]  <= se_s2[k];
			sl_s3[k]  <= sl_s2[k];
			c_p_s3[k] <= c1_s2[k] * $signed({1'b0, hl_s2});
			wt_s3[k]  <= wt_s2[k];

			val_s4[k] <= val_s3[k];
			se_s4[k]  <= se_s3[k];
			sl_s4[k]  <= sl_s3[k];
			c_s4[k]   <= sat_data(AW'(c_p_s3[k] >>> 16));
			wt_s4[k]  <= wt_s3[k];

			term_s5[k][0] <= val_s4[k] * wt_s4[k][0];
			term_s5[k][1] <= se_s4[k] * wt_s4[k][1];
			term_s5[k][2] <= sl_s4[k] * wt_s4[k][2];
			term_s5[k][3] <= c_s4[k] * wt_s4[k][3];

			grp_s6[k] <= term_s5[k][0] + term_s5[k][1] + term_s5[k][2] + term_s5[k][3];
		end
		acc_s7   <= grp_s6[0] + grp_s6[1] + grp_s6[2] + grp_s6[3];
		value_s8 <= sat_data(acc_s7 >>> FW);
	end

	assign value = value_s8;

endmodule

FILE: rtl/bicubic_hermite_grid_interp.sv
// ----------------------------------------------------------------------------
// bicubic_hermite_grid_interp: bicubic Hermite interpolation over a stored grid.
// Each accepted request raises done after the axis, grid and sum pipelines; one request per cycle.
// busy never rises; the axis depth follows the longer of its two pipelined dividers, the cell position one.
// Reset restores the register defaults and empties the pipeline; the grid is not cleared.
// ----------------------------------------------------------------------------
module bicubic_hermite_grid_interp #(
	parameter int MAX_FIRST_POINTS  = 64,
	parameter int MAX_SECOND_POINTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  bchi_pkg::request_t                  req,
	output logic                                done,
	output bchi_pkg::result_t                   rsp,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bchi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bchi_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int AL = bchi_pkg::AXIS_LAT;
	localparam int TL = bchi_pkg::TOTAL_LAT;
	localparam int PW = bchi_pkg::COORD_W;
	localparam int CW = bchi_pkg::CNT_W;

	logic [PW-1:0] energy_min_q, energy_max_q, baseline_min_q, baseline_max_q;
	logic [CW-1:0] energy_points_q, baseline_points_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_min_q      <= '0;
			energy_max_q      <= '1;
			baseline_min_q    <= '0;
			baseline_max_q    <= '1;
			energy_points_q   <= CW'(64);
			baseline_points_q <= CW'(64);
		end else if (cfg_valid && cfg_ready) begin
			unique case (bchi_pkg::cfg_reg_t'(cfg_index))
				bchi_pkg::REG_ENERGY_MIN:      energy_min_q      <= cfg_data;
				bchi_pkg::REG_ENERGY_MAX:      energy_max_q      <= cfg_data;
				bchi_pkg::REG_BASELINE_MIN:    baseline_min_q    <= cfg_data;
				bchi_pkg::REG_BASELINE_MAX:    baseline_max_q    <= cfg_data;
				bchi_pkg::REG_ENERGY_POINTS:   energy_points_q   <= cfg_data[CW-1:0];
				bchi_pkg::REG_BASELINE_POINTS: baseline_points_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	logic accept;
	assign accept = start && !busy;

	logic [TL:1] valid_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= {valid_s[TL-1:1], accept};
		end
	end

	bchi_pkg::request_t item_s [1:AL];

	always_ff @(posedge clk) begin
		item_s[1] <= req;
		for (int k = 2; k <= AL; k++) begin
			item_s[k] <= item_s[k-1];
		end
	end

	bchi_pkg::axis_t geo_e, geo_l, geo_e_s17, geo_l_s17;

	bchi_axis #(.MAX_POINTS(MAX_FIRST_POINTS)) u_axis_e (
		.clk   (clk),
		.q     (req.query_energy),
		.lo    (energy_min_q),
		.hi    (energy_max_q),
		.points(energy_points_q),
		.geo   (geo_e)
	);

	bchi_axis #(.MAX_POINTS(MAX_SECOND_POINTS)) u_axis_l (
		.clk   (clk),
		.q     (req.query_baseline),
		.lo    (baseline_min_q),
		.hi    (baseline_max_q),
		.points(baseline_points_q),
		.geo   (geo_l)
	);

	bchi_pkg::point_t        wr_point;
	bchi_pkg::point_t [3:0]  corner;
	logic                    wr_en;

	always_comb begin
		wr_en                 = valid_s[AL] && item_s[AL].operation == bchi_pkg::OP_WRITE;
		wr_point.value        = item_s[AL].point_value;
		wr_point.first_slope  = item_s[AL].slope_first_axis;
		wr_point.second_slope = item_s[AL].slope_second_axis;
		wr_point.mixed_slope  = item_s[AL].cross_slope;
	end

	bchi_grid #(
		.MAX_F(MAX_FIRST_POINTS),
		.MAX_S(MAX_SECOND_POINTS)
	) u_grid (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_e   (item_s[AL].energy_point),
		.wr_l   (item_s[AL].baseline_point),
		.wr_data(wr_point),
		.rd_i   (geo_e.cell_idx),
		.rd_j   (geo_l.cell_idx),
		.corner (corner)
	);

	logic query_s [AL+1:TL];
	logic ok_s [AL+1:TL];

	always_ff @(posedge clk) begin
		geo_e_s17     <= geo_e;
		geo_l_s17     <= geo_l;
		query_s[AL+1] <= item_s[AL].operation == bchi_pkg::OP_QUERY;
		ok_s[AL+1]    <= geo_e.ok && geo_l.ok;
		for (int k = AL + 2; k <= TL; k++) begin
			query_s[k] <= query_s[k-1];
			ok_s[k]    <= ok_s[k-1];
		end
	end

	logic signed [bchi_pkg::DATA_W-1:0] sum_value;

	bchi_sum u_sum (
		.clk   (clk),
		.corner(corner),
		.geo_e (geo_e_s17),
		.geo_l (geo_l_s17),
		.value (sum_value)
	);

	always_comb begin
		done             = valid_s[TL];
		rsp.interpolated = (query_s[TL] && ok_s[TL]) ? sum_value : '0;
		rsp.off_grid     = query_s[TL] && !ok_s[TL];
	end

endmodule

FILE: verif/bicubic_hermite_grid_interp_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bicubic Hermite grid interpolator checker
// Watches the request, result and register channels of the interpolator,
// keeps its own copy of the grid and the registers, predicts each result and
// compares it field by field with what the block gives.
// ----------------------------------------------------------------------------
module bicubic_hermite_grid_interp_check #(
	parameter int MAX_FIRST_POINTS  = 64,
	parameter int MAX_SECOND_POINTS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  bchi_pkg::request_t              req,
	input  logic                            done,
	input  bchi_pkg::result_t               rsp,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [bchi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bchi_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              errors,
	output int                              pending
);

	localparam int DEPTH = MAX_FIRST_POINTS * MAX_SECOND_POINTS;

	int                grid_value [DEPTH];
	int                grid_first [DEPTH];
	int                grid_second[DEPTH];
	int                grid_cross [DEPTH];
	longint            e_lo, e_hi, b_lo, b_hi, e_pts, b_pts;
	bchi_pkg::result_t expected_q[$];

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint scale_slope(input longint s, input longint h);
		return sat32((s * h) >>> 16);
	endfunction

	function automatic void locate_cell(input longint q, input longint lo, input longint hi,
			input longint n, input longint maxn, output bit ok, output longint cell_idx,
			output longint w0, output longint w1, output longint w2, output longint w3,
			output longint h);
		longint span, cells, p, num, t, t2, t3;
		ok = 0; cell_idx = 0; w0 = 0; w1 = 0; w2 = 0; w3 = 0; h = 0;
		if (hi <= lo || q < lo || q > hi)
			return;
		span     = hi - lo;
		cells    = ((n < 2) ? 2 : (n > maxn) ? maxn : n) - 1;
		p        = q - lo;
		cell_idx = (p * cells) / span;
		if (cell_idx >= cells)
			cell_idx = cells - 1;
		num = p * cells - cell_idx * span;
		t   = (num << 23) / span;
		t2  = (t * t) >>> 23;
		t3  = (t2 * t) >>> 23;
		w0  = (64'sd1 << 23) - 3 * t2 + 2 * t3;
		w1  = t - 2 * t2 + t3;
		w2  = 3 * t2 - 2 * t3;
		w3  = t3 - t2;
		h   = (span << 16) / cells;
		ok  = 1;
	endfunction

	function automatic bchi_pkg::result_t predict_interp(input bchi_pkg::request_t r);
		bchi_pkg::result_t res;
		bit      ok_e, ok_b;
		longint  ce, cb, he, hb, acc, v, se, sb, sc;
		longint  we[4], wb[4];
		int      k;
		res = '0;
		locate_cell(r.query_energy, e_lo, e_hi, e_pts, MAX_FIRST_POINTS,
			ok_e, ce, we[0], we[1], we[2], we[3], he);
		locate_cell(r.query_baseline, b_lo, b_hi, b_pts, MAX_SECOND_POINTS,
			ok_b, cb, wb[0], wb[1], wb[2], wb[3], hb);
		if (!ok_e || !ok_b) begin
			res.off_grid = 1'b1;
			return res;
		end
		acc = 0;
		for (int a = 0; a < 2; a++) begin
			for (int b = 0; b < 2; b++) begin
				k   = int'((ce + a) * MAX_SECOND_POINTS + (cb + b));
				v   = grid_value[k];
				se  = scale_slope(grid_first[k], he);
				sb  = scale_slope(grid_second[k], hb);
				sc  = scale_slope(scale_slope(grid_cross[k], he), hb);
				acc += v  * ((we[2*a]   * wb[2*b])   >>> 23);
				acc += se * ((we[2*a+1] * wb[2*b])   >>> 23);
				acc += sb * ((we[2*a]   * wb[2*b+1]) >>> 23);
				acc += sc * ((we[2*a+1] * wb[2*b+1]) >>> 23);
			end
		end
		res.interpolated = 32'(sat32(acc >>> 23));
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		errors  = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		bchi_pkg::result_t want;
		int      k;
		if (!arst_n) begin
			expected_q.delete();
			e_lo  = 0;
			e_hi  = 65535;
			b_lo  = 0;
			b_hi  = 65535;
			e_pts = 64;
			b_pts = 64;
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result", rsp.interpolated, 0);
				end else begin
					want = expected_q.pop_front();
					if (rsp.interpolated !== want.interpolated)
						report_mismatch("interpolated", rsp.interpolated, want.interpolated);
					if (rsp.off_grid !== want.off_grid)
						report_mismatch("off_grid", rsp.off_grid, want.off_grid);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (bchi_pkg::cfg_reg_t'(cfg_index))
					bchi_pkg::REG_ENERGY_MIN:      e_lo  = cfg_data;
					bchi_pkg::REG_ENERGY_MAX:      e_hi  = cfg_data;
					bchi_pkg::REG_BASELINE_MIN:    b_lo  = cfg_data;
					bchi_pkg::REG_BASELINE_MAX:    b_hi  = cfg_data;
					bchi_pkg::REG_ENERGY_POINTS:   e_pts = cfg_data[bchi_pkg::CNT_W-1:0];
					bchi_pkg::REG_BASELINE_POINTS: b_pts = cfg_data[bchi_pkg::CNT_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (req.operation == bchi_pkg::OP_WRITE) begin
					if (req.energy_point < MAX_FIRST_POINTS &&
							req.baseline_point < MAX_SECOND_POINTS) begin
						k = req.energy_point * MAX_SECOND_POINTS + req.baseline_point;
						grid_value[k]  = req.point_value;
						grid_first[k]  = req.slope_first_axis;
						grid_second[k] = req.slope_second_axis;
						grid_cross[k]  = req.cross_slope;
					end
					want = '0;
				end else begin
					want = predict_interp(req);
				end
				expected_q = {expected_q, want};
			end
		end
		pending = expected_q.size();
	end

endmodule

FILE: verif/bicubic_hermite_grid_interp_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bicubic Hermite grid interpolator testbench
// Fills the grid points whose two indices each lie at or below 8 or at or
// above 62, then runs directed and random grid writes and queries under several
// register settings with random gaps, while a checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module bicubic_hermite_grid_interp_test;

	localparam longint CYCLE_LIMIT = 100000;

	logic                            clk;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	bchi_pkg::request_t              req;
	logic                            done;
	bchi_pkg::result_t               rsp;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [bchi_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bchi_pkg::CFG_DATA_W-1:0] cfg_data;
	int                              errors;
	int                              pending;
	longint                          cycles;
	bit                              steady;
	int                              axis_lo[2], axis_hi[2];

	bicubic_hermite_grid_interp dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	bicubic_hermite_grid_interp_check checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_request(input bchi_pkg::request_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (bchi_pkg::TOTAL_LAT + 5) @(posedge clk);
	endtask

	task automatic write_reg(input bchi_pkg::cfg_reg_t idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= bchi_pkg::CFG_DATA_W'(value);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic set_grid(input int elo, input int ehi, input int blo, input int bhi,
			input int epts, input int bpts);
		drain();
		write_reg(bchi_pkg::REG_ENERGY_MIN, elo);
		write_reg(bchi_pkg::REG_ENERGY_MAX, ehi);
		write_reg(bchi_pkg::REG_BASELINE_MIN, blo);
		write_reg(bchi_pkg::REG_BASELINE_MAX, bhi);
		write_reg(bchi_pkg::REG_ENERGY_POINTS, epts);
		write_reg(bchi_pkg::REG_BASELINE_POINTS, bpts);
		cfg_valid <= 1'b0;
		axis_lo[0] = elo;
		axis_hi[0] = ehi;
		axis_lo[1] = blo;
		axis_hi[1] = bhi;
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0:       return 32'h7fffffff;
			1:       return 32'h80000000;
			2:       return 32'h0;
			3, 4:    return 32'($urandom_range(0, 32'h01ffffff)) - 32'h01000000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_coord(input int ax);
		int lo, hi;
		lo = axis_lo[ax];
		hi = axis_hi[ax];
		case ($urandom_range(0, 9))
			0:       return 16'(lo);
			1:       return 16'(hi);
			2:       return 16'(lo - 1);
			3:       return 16'(hi + 1);
			4:       return 16'($urandom);
			default: return (lo <= hi) ? 16'($urandom_range(lo, hi)) : 16'($urandom);
		endcase
	endfunction

	function automatic bchi_pkg::request_t grid_write(input int e, input int b,
			input bit extreme);
		bchi_pkg::request_t r;
		r = bchi_pkg::request_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		r.operation         = bchi_pkg::OP_WRITE;
		r.energy_point      = bchi_pkg::IDX_W'(e);
		r.baseline_point    = bchi_pkg::IDX_W'(b);
		r.point_value       = extreme ? 32'h7fffffff : pick_word();
		r.slope_first_axis  = extreme ? 32'h80000000 : pick_word();
		r.slope_second_axis = extreme ? 32'h7fffffff : pick_word();
		r.cross_slope       = extreme ? 32'h80000000 : pick_word();
		return r;
	endfunction

	function automatic bchi_pkg::request_t grid_query(input int qe, input int qb);
		bchi_pkg::request_t r;
		r = bchi_pkg::request_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		r.operation      = bchi_pkg::OP_QUERY;
		r.query_energy   = 16'(qe);
		r.query_baseline = 16'(qb);
		return r;
	endfunction

	task automatic random_mix(input int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 30)
				send_request(grid_write($urandom_range(0, 63), $urandom_range(0, 63), 0));
			else
				send_request(grid_query(pick_coord(0), pick_coord(1)));
			if (n % 40 == 0)
				steady = ($urandom_range(0, 3) == 0);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		steady    = 1'b0;
		axis_lo   = '{0, 0};
		axis_hi   = '{65535, 65535};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		steady = 1'b1;
		for (int e = 0; e < 64; e++)
			for (int b = 0; b < 64; b++)
				if ((e <= 8 || e >= 62) && (b <= 8 || b >= 62))
					send_request(grid_write(e, b, 0));
		steady = 1'b0;

		send_request(grid_write(0, 0, 1));
		send_request(grid_write(63, 63, 1));
		send_request(grid_write(0, 63, 0));
		send_request(grid_write(63, 0, 0));
		send_request(grid_query(0, 0));
		send_request(grid_query(65535, 65535));
		send_request(grid_query(65535, 0));
		send_request(grid_query(0, 65535));
		send_request(grid_query(1000, 1));
		set_grid(100, 2000, 300, 40000, 5, 9);
		send_request(grid_query(99, 300));
		send_request(grid_query(100, 299));
		send_request(grid_query(2001, 300));
		send_request(grid_query(2000, 40001));
		send_request(grid_query(2000, 40000));
		send_request(grid_query(100, 300));
		send_request(grid_query(575, 4762));
		random_mix(70);

		set_grid(0, 65535, 0, 65535, 2, 2);
		send_request(grid_query(65535, 65535));
		random_mix(40);
		set_grid(7, 9, 65534, 65535, 0, 127);
		random_mix(30);
		set_grid(500, 500, 1000, 10, 1, 64);
		random_mix(15);
		set_grid(1234, 50000, 77, 12345, 8, 3);
		random_mix(55);
		set_grid(0, 65535, 0, 65535, 9, 9);
		random_mix(55);

		drain();
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: bicubic_hermite_grid_interp.f
rtl/bchi_pkg.sv
rtl/bchi_div.sv
rtl/bchi_axis.sv
rtl/bchi_grid.sv
rtl/bchi_sum.sv
rtl/bicubic_hermite_grid_interp.sv
verif/bicubic_hermite_grid_interp_check.sv
verif/bicubic_hermite_grid_interp_test.sv
